@@ design/cau_pkg.sv @@
// ----------------------------------------------------------------------------
// cau_pkg
// Shared opcodes, status codes and default widths of the complex arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none

package cau_pkg;

  localparam int OP_W = 3;
  localparam int ST_W = 2;

  localparam int FRAC_BITS_DEF = 16;
  localparam int WORD_BITS_DEF = 32;

  localparam logic [OP_W-1:0] OP_ADD  = 3'd0;
  localparam logic [OP_W-1:0] OP_SUB  = 3'd1;
  localparam logic [OP_W-1:0] OP_MUL  = 3'd2;
  localparam logic [OP_W-1:0] OP_DIV  = 3'd3;
  localparam logic [OP_W-1:0] OP_MAG  = 3'd4;
  localparam logic [OP_W-1:0] OP_SQRT = 3'd5;
  localparam logic [OP_W-1:0] OP_NEG  = 3'd6;
  localparam logic [OP_W-1:0] OP_PASS = 3'd7;

  localparam logic [ST_W-1:0] ST_OK   = 2'd0;
  localparam logic [ST_W-1:0] ST_OVF  = 2'd1;
  localparam logic [ST_W-1:0] ST_DIVZ = 2'd2;

endpackage

`default_nettype wire

@@ design/cau_div_pipe.sv @@
// ----------------------------------------------------------------------------
// cau_div_pipe
// Pipelined restoring divider, one quotient bit per stage, several lanes
// sharing one divisor. A tag travels alongside the data.
// ----------------------------------------------------------------------------
`default_nettype none

module cau_div_pipe #(
  parameter int DW    = 64,
  parameter int QW    = 32,
  parameter int LANES = 2,
  parameter int TAG_W = 4
) (
  input  logic                           clk,
  input  logic [DW-1:0]                  den_i,
  input  logic [LANES-1:0][DW-1:0]       rem_i,
  input  logic [LANES-1:0][QW-1:0]       low_i,
  input  logic [TAG_W-1:0]               tag_i,
  output logic [LANES-1:0][QW-1:0]       quo_o,
  output logic [TAG_W-1:0]               tag_o
);

  logic [DW-1:0]    den_r [QW];
  logic [TAG_W-1:0] tag_r [QW];
  logic [DW-1:0]    rem_r [QW][LANES];
  logic [QW-1:0]    low_r [QW][LANES];
  logic [QW-1:0]    quo_r [QW][LANES];

  for (genvar s = 0; s < QW; s++) begin : g_st
    logic [DW-1:0]    den_in;
    logic [TAG_W-1:0] tag_in;

    if (s == 0) begin : g_first
      assign den_in = den_i;
      assign tag_in = tag_i;
    end else begin : g_next
      assign den_in = den_r[s-1];
      assign tag_in = tag_r[s-1];
    end

    always_ff @(posedge clk) begin
      den_r[s] <= den_in;
      tag_r[s] <= tag_in;
    end

    for (genvar l = 0; l < LANES; l++) begin : g_ln
      logic [DW-1:0] rem_in;
      logic [QW-1:0] low_in;
      logic [QW-1:0] quo_in;
      logic [DW:0]   trial;
      logic [DW-1:0] rem_nxt;
      logic [QW-1:0] quo_nxt;

      if (s == 0) begin : g_first
        assign rem_in = rem_i[l];
        assign low_in = low_i[l];
        assign quo_in = '0;
      end else begin : g_next
        assign rem_in = rem_r[s-1][l];
        assign low_in = low_r[s-1][l];
        assign quo_in = quo_r[s-1][l];
      end

      always_comb begin
        trial = {rem_in, low_in[QW-1]};
        if (trial >= {1'b0, den_in}) begin
          rem_nxt = DW'(trial - {1'b0, den_in});
          quo_nxt = {quo_in[QW-2:0], 1'b1};
        end else begin
          rem_nxt = trial[DW-1:0];
          quo_nxt = {quo_in[QW-2:0], 1'b0};
        end
      end

      always_ff @(posedge clk) begin
        rem_r[s][l] <= rem_nxt;
        low_r[s][l] <= low_in << 1;
        quo_r[s][l] <= quo_nxt;
      end
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_out
    assign quo_o[l] = quo_r[QW-1][l];
  end
  assign tag_o = tag_r[QW-1];

endmodule

`default_nettype wire

@@ design/cau_isqrt_pipe.sv @@
// ----------------------------------------------------------------------------
// cau_isqrt_pipe
// Pipelined digit-by-digit integer square root, one root bit per stage,
// several independent lanes. A valid bit and a tag travel with the data.
// ----------------------------------------------------------------------------
`default_nettype none

module cau_isqrt_pipe #(
  parameter int AW    = 64,
  parameter int LANES = 1,
  parameter int TAG_W = 1
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                vld_i,
  input  logic [LANES-1:0][AW-1:0]            arg_i,
  input  logic [TAG_W-1:0]                    tag_i,
  output logic                                vld_o,
  output logic [LANES-1:0][(AW+1)/2-1:0]      root_o,
  output logic [TAG_W-1:0]                    tag_o
);

  localparam int RW   = (AW + 1) / 2;
  localparam int PAW  = 2 * RW;
  localparam int REMW = RW + 2;

  logic             vld_r  [RW];
  logic [TAG_W-1:0] tag_r  [RW];
  logic [REMW-1:0]  rem_r  [RW][LANES];
  logic [RW-1:0]    root_r [RW][LANES];
  logic [PAW-1:0]   arg_r  [RW][LANES];

  for (genvar s = 0; s < RW; s++) begin : g_st
    logic             vld_in;
    logic [TAG_W-1:0] tag_in;

    if (s == 0) begin : g_first
      assign vld_in = vld_i;
      assign tag_in = tag_i;
    end else begin : g_next
      assign vld_in = vld_r[s-1];
      assign tag_in = tag_r[s-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else begin
        vld_r[s] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      tag_r[s] <= tag_in;
    end

    for (genvar l = 0; l < LANES; l++) begin : g_ln
      logic [REMW-1:0] rem_in;
      logic [RW-1:0]   root_in;
      logic [PAW-1:0]  arg_in;
      logic [REMW-1:0] rem_sh;
      logic [REMW-1:0] trial;
      logic [REMW-1:0] rem_nxt;
      logic [RW-1:0]   root_nxt;

      if (s == 0) begin : g_first
        assign rem_in  = '0;
        assign root_in = '0;
        assign arg_in  = PAW'(arg_i[l]);
      end else begin : g_next
        assign rem_in  = rem_r[s-1][l];
        assign root_in = root_r[s-1][l];
        assign arg_in  = arg_r[s-1][l];
      end

      // Bring down the next two argument bits and try appending a one to the root.
      always_comb begin
        rem_sh = {rem_in[REMW-3:0], arg_in[PAW-1 -: 2]};
        trial  = {root_in, 2'b01};
        if (rem_sh >= trial) begin
          rem_nxt  = rem_sh - trial;
          root_nxt = {root_in[RW-2:0], 1'b1};
        end else begin
          rem_nxt  = rem_sh;
          root_nxt = {root_in[RW-2:0], 1'b0};
        end
      end

      always_ff @(posedge clk) begin
        rem_r[s][l]  <= rem_nxt;
        root_r[s][l] <= root_nxt;
        arg_r[s][l]  <= arg_in << 2;
      end
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_out
    assign root_o[l] = root_r[RW-1][l];
  end
  assign vld_o = vld_r[RW-1];
  assign tag_o = tag_r[RW-1];

endmodule

`default_nettype wire

@@ design/complex_arithmetic_unit.sv @@
// The delay from the accepting edge to the out_valid pulse is the same for every opcode;
// the default format is Q16.16.
// Throughput: one item per cycle; busy never asserts and the result strobe cannot stall.
// The depth is set by the magnitude square root (one bit per stage) followed by the
// half-angle square roots (one bit per stage); the divider runs beside the first root.
// Reset clears only the valid bits of the pipeline; data registers are not reset.
// ----------------------------------------------------------------------------
// complex_arithmetic_unit
// Fully pipelined fixed-point complex ALU: add, subtract, multiply, divide,
// magnitude, square root, negate and pass, with saturation and divide-by-zero status.
// ----------------------------------------------------------------------------
`default_nettype none

module complex_arithmetic_unit #(
  parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF,
  parameter int WORD_BITS = cau_pkg::WORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [cau_pkg::OP_W-1:0]      in_opcode,
  input  logic signed [WORD_BITS-1:0]   in_a_re,
  input  logic signed [WORD_BITS-1:0]   in_a_im,
  input  logic signed [WORD_BITS-1:0]   in_b_re,
  input  logic signed [WORD_BITS-1:0]   in_b_im,
  output logic                          out_valid,
  output logic signed [WORD_BITS-1:0]   out_res_re,
  output logic signed [WORD_BITS-1:0]   out_res_im,
  output logic signed [WORD_BITS-1:0]   out_alt_re,
  output logic signed [WORD_BITS-1:0]   out_alt_im,
  output logic [cau_pkg::ST_W-1:0]      out_status
);

  import cau_pkg::*;

  localparam int W   = WORD_BITS;
  localparam int F   = FRAC_BITS;
  localparam int PW  = 2 * W;
  localparam int SW  = 2 * W + 1;
  localparam int MW  = 2 * W + 1;
  localparam int NW  = 2 * W + F;
  localparam int CW  = 3 * W + F;
  localparam int AW2 = W + F;
  localparam int RW2 = (AW2 + 1) / 2;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic [W-1:0]    re;
    logic [W-1:0]    im;
    logic [ST_W-1:0] st;
    logic            kz;
    logic [W-1:0]    ar;
    logic            ai_neg;
  } side_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic [W-1:0]    re;
    logic [W-1:0]    im;
    logic [ST_W-1:0] st;
    logic            ai_neg;
  } late_t;

  typedef struct packed {
    logic neg_re;
    logic neg_im;
    logic ovf_re;
    logic ovf_im;
  } dtag_t;

  // Saturate a sign and magnitude to a word; the top bit of the result flags a clip.
  function automatic logic [W:0] sat_fn(input logic neg, input logic ovf,
                                        input logic [MW-1:0] mag);
    logic [MW-1:0] lim;
    logic [W-1:0]  val;
    logic          hit;
    lim = neg ? (MW'(1) << (W - 1)) : ((MW'(1) << (W - 1)) - MW'(1));
    hit = ovf || (mag > lim);
    val = hit ? lim[W-1:0] : mag[W-1:0];
    val = neg ? (-val) : val;
    return {hit, val};
  endfunction

  function automatic logic [W:0] abs_fn(input logic signed [W:0] v);
    return v[W] ? $unsigned(-v) : $unsigned(v);
  endfunction

  assign busy = 1'b0;

  // ---------------------------------------------------------------- stage 0
  logic                  s0_vld_r;
  logic [OP_W-1:0]       s0_op_r;
  logic signed [W-1:0]   s0_ar_r, s0_ai_r, s0_br_r, s0_bi_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else begin
      s0_vld_r <= start & ~busy;
    end
  end

  always_ff @(posedge clk) begin
    s0_op_r <= in_opcode;
    s0_ar_r <= in_a_re;
    s0_ai_r <= in_a_im;
    s0_br_r <= in_b_re;
    s0_bi_r <= in_b_im;
  end

  // ---------------------------------------------------------------- stage 1
  logic signed [W:0]   sum_re, sum_im, ar_x, ai_x;
  logic [W:0]          sat_re, sat_im;
  logic signed [W-1:0] sq_x, sq_y;
  side_t               s1_side_nxt;

  always_comb begin
    ar_x = s0_ar_r;
    ai_x = s0_ai_r;
    if (s0_op_r == OP_SUB) begin
      sum_re = s0_ar_r - s0_br_r;
      sum_im = s0_ai_r - s0_bi_r;
    end else begin
      sum_re = s0_ar_r + s0_br_r;
      sum_im = s0_ai_r + s0_bi_r;
    end
    if (s0_op_r == OP_NEG) begin
      sat_re = sat_fn(s0_ar_r > 0, 1'b0, MW'(abs_fn(ar_x)));
      sat_im = sat_fn(s0_ai_r > 0, 1'b0, MW'(abs_fn(ai_x)));
    end else begin
      sat_re = sat_fn(sum_re[W], 1'b0, MW'(abs_fn(sum_re)));
      sat_im = sat_fn(sum_im[W], 1'b0, MW'(abs_fn(sum_im)));
    end

    s1_side_nxt        = '0;
    s1_side_nxt.op     = s0_op_r;
    s1_side_nxt.ar     = s0_ar_r;
    s1_side_nxt.ai_neg = s0_ai_r[W-1];
    unique case (s0_op_r)
      OP_ADD, OP_SUB, OP_NEG: begin
        s1_side_nxt.re = sat_re[W-1:0];
        s1_side_nxt.im = sat_im[W-1:0];
        s1_side_nxt.st = (sat_re[W] | sat_im[W]) ? ST_OVF : ST_OK;
      end
      OP_PASS: begin
        s1_side_nxt.re = s0_ar_r;
        s1_side_nxt.im = s0_ai_r;
        s1_side_nxt.st = ST_OK;
      end
      default: begin
        s1_side_nxt.st = ST_OK;
      end
    endcase

    // Division needs |b|^2; magnitude and root need |a|^2.
    sq_x = (s0_op_r == OP_DIV) ? s0_br_r : s0_ar_r;
    sq_y = (s0_op_r == OP_DIV) ? s0_bi_r : s0_ai_r;
  end

  logic                 s1_vld_r;
  side_t                s1_side_r;
  logic signed [PW-1:0] s1_p0_r, s1_p1_r, s1_p2_r, s1_p3_r, s1_p4_r, s1_p5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s0_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_side_r <= s1_side_nxt;
    s1_p0_r   <= s0_ar_r * s0_br_r;
    s1_p1_r   <= s0_ai_r * s0_bi_r;
    s1_p2_r   <= s0_ar_r * s0_bi_r;
    s1_p3_r   <= s0_ai_r * s0_br_r;
    s1_p4_r   <= sq_x * sq_x;
    s1_p5_r   <= sq_y * sq_y;
  end

  // ---------------------------------------------------------------- stage 2
  logic                 s2_vld_r;
  side_t                s2_side_r;
  logic signed [SW-1:0] s2_sre_r, s2_sim_r;
  logic [PW-1:0]        s2_k_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_side_r <= s1_side_r;
    if (s1_side_r.op == OP_MUL) begin
      s2_sre_r <= s1_p0_r - s1_p1_r;
      s2_sim_r <= s1_p2_r + s1_p3_r;
    end else begin
      s2_sre_r <= s1_p0_r + s1_p1_r;
      s2_sim_r <= s1_p3_r - s1_p2_r;
    end
    s2_k_r <= $unsigned(s1_p4_r) + $unsigned(s1_p5_r);
  end

  // ---------------------------------------------------------------- stage 3
  logic          s3_vld_r;
  side_t         s3_side_nxt;
  side_t         s3_side_r;
  logic [PW-1:0] s3_mre_r, s3_mim_r, s3_k_r;
  logic          s3_nre_r, s3_nim_r;

  always_comb begin
    s3_side_nxt    = s2_side_r;
    s3_side_nxt.kz = (s2_k_r == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s3_side_r    <= s3_side_nxt;
    s3_nre_r     <= s2_sre_r[SW-1];
    s3_nim_r     <= s2_sim_r[SW-1];
    s3_mre_r     <= s2_sre_r[SW-1] ? PW'($unsigned(-s2_sre_r)) : PW'($unsigned(s2_sre_r));
    s3_mim_r     <= s2_sim_r[SW-1] ? PW'($unsigned(-s2_sim_r)) : PW'($unsigned(s2_sim_r));
    s3_k_r       <= s2_k_r;
  end

  // ---------------------------------------------------------------- stage 4
  logic [W:0]    mul_re, mul_im;
  logic [NW-1:0] num_re, num_im;
  side_t         s4_side_nxt;
  dtag_t         s4_dtag_nxt;

  always_comb begin
    mul_re = sat_fn(s3_nre_r, 1'b0, MW'(s3_mre_r >> F));
    mul_im = sat_fn(s3_nim_r, 1'b0, MW'(s3_mim_r >> F));
    s4_side_nxt = s3_side_r;
    if (s3_side_r.op == OP_MUL) begin
      s4_side_nxt.re = mul_re[W-1:0];
      s4_side_nxt.im = mul_im[W-1:0];
      s4_side_nxt.st = (mul_re[W] | mul_im[W]) ? ST_OVF : ST_OK;
    end

    // The quotient fits in a word only if the scaled numerator is below k * 2^W.
    num_re = {s3_mre_r, {F{1'b0}}};
    num_im = {s3_mim_r, {F{1'b0}}};
    s4_dtag_nxt.neg_re = s3_nre_r;
    s4_dtag_nxt.neg_im = s3_nim_r;
    s4_dtag_nxt.ovf_re = CW'(num_re) >= (CW'(s3_k_r) << W);
    s4_dtag_nxt.ovf_im = CW'(num_im) >= (CW'(s3_k_r) << W);
  end

  logic                   s4_vld_r;
  side_t                  s4_side_r;
  dtag_t                  s4_dtag_r;
  logic [PW-1:0]          s4_k_r;
  logic [1:0][PW-1:0]     s4_rem_r;
  logic [1:0][W-1:0]      s4_low_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else begin
      s4_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s4_side_r   <= s4_side_nxt;
    s4_dtag_r   <= s4_dtag_nxt;
    s4_k_r      <= s3_k_r;
    s4_rem_r[0] <= PW'(num_re >> W);
    s4_rem_r[1] <= PW'(num_im >> W);
    s4_low_r[0] <= num_re[W-1:0];
    s4_low_r[1] <= num_im[W-1:0];
  end

  // ------------------------------------------- divider and magnitude root
  logic [1:0][W-1:0] div_quo;
  dtag_t             div_tag;
  logic [0:0][W-1:0] mag_root;
  side_t             mag_side;
  logic              mag_vld;

  cau_div_pipe #(
    .DW    (PW),
    .QW    (W),
    .LANES (2),
    .TAG_W ($bits(dtag_t))
  ) u_div (
    .clk   (clk),
    .den_i (s4_k_r),
    .rem_i (s4_rem_r),
    .low_i (s4_low_r),
    .tag_i (s4_dtag_r),
    .quo_o (div_quo),
    .tag_o (div_tag)
  );

  cau_isqrt_pipe #(
    .AW    (PW),
    .LANES (1),
    .TAG_W ($bits(side_t))
  ) u_mag (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_i  (s4_vld_r),
    .arg_i  (s4_k_r),
    .tag_i  (s4_side_r),
    .vld_o  (mag_vld),
    .root_o (mag_root),
    .tag_o  (mag_side)
  );

  // ---------------------------------------------------------- merge stage
  logic [W:0]          quo_re, quo_im, mag_sat;
  logic signed [W+1:0] half_re, half_im;
  late_t               sp_late_nxt;

  always_comb begin
    quo_re  = sat_fn(div_tag.neg_re, div_tag.ovf_re, MW'(div_quo[0]));
    quo_im  = sat_fn(div_tag.neg_im, div_tag.ovf_im, MW'(div_quo[1]));
    mag_sat = sat_fn(1'b0, 1'b0, MW'(mag_root[0]));
    half_re = $signed({2'b00, mag_root[0]}) + $signed(mag_side.ar);
    half_im = $signed({2'b00, mag_root[0]}) - $signed(mag_side.ar);

    sp_late_nxt.op     = mag_side.op;
    sp_late_nxt.ai_neg = mag_side.ai_neg;
    sp_late_nxt.re     = mag_side.re;
    sp_late_nxt.im     = mag_side.im;
    sp_late_nxt.st     = mag_side.st;
    unique case (mag_side.op)
      OP_DIV: begin
        if (mag_side.kz) begin
          sp_late_nxt.re = '0;
          sp_late_nxt.im = '0;
          sp_late_nxt.st = ST_DIVZ;
        end else begin
          sp_late_nxt.re = quo_re[W-1:0];
          sp_late_nxt.im = quo_im[W-1:0];
          sp_late_nxt.st = (quo_re[W] | quo_im[W]) ? ST_OVF : ST_OK;
        end
      end
      OP_MAG: begin
        sp_late_nxt.re = mag_sat[W-1:0];
        sp_late_nxt.im = '0;
        sp_late_nxt.st = mag_sat[W] ? ST_OVF : ST_OK;
      end
      default: begin
        sp_late_nxt.re = mag_side.re;
      end
    endcase
  end

  logic               sp_vld_r;
  late_t              sp_late_r;
  logic [1:0][AW2-1:0] sp_arg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_vld_r <= 1'b0;
    end else begin
      sp_vld_r <= mag_vld;
    end
  end

  // Root argument is ((M +/- re) << F) >> 1, i.e. a shift by F-1.
  always_ff @(posedge clk) begin
    sp_late_r   <= sp_late_nxt;
    sp_arg_r[0] <= {half_re[W:0], {(F-1){1'b0}}};
    sp_arg_r[1] <= {half_im[W:0], {(F-1){1'b0}}};
  end

  // --------------------------------------------------------- half roots
  logic [1:0][RW2-1:0] rt_root;
  late_t               rt_late;
  logic                rt_vld;

  cau_isqrt_pipe #(
    .AW    (AW2),
    .LANES (2),
    .TAG_W ($bits(late_t))
  ) u_root (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_i  (sp_vld_r),
    .arg_i  (sp_arg_r),
    .tag_i  (sp_late_r),
    .vld_o  (rt_vld),
    .root_o (rt_root),
    .tag_o  (rt_late)
  );

  // ---------------------------------------------------------- output stage
  logic [W:0]      rt_re, rt_im;
  logic [W-1:0]    res_re_nxt, res_im_nxt, alt_re_nxt, alt_im_nxt;
  logic [ST_W-1:0] st_nxt;

  always_comb begin
    rt_re = sat_fn(1'b0, 1'b0, MW'(rt_root[0]));
    rt_im = sat_fn(rt_late.ai_neg, 1'b0, MW'(rt_root[1]));
    if (rt_late.op == OP_SQRT) begin
      res_re_nxt = rt_re[W-1:0];
      res_im_nxt = rt_im[W-1:0];
      alt_re_nxt = -rt_re[W-1:0];
      alt_im_nxt = -rt_im[W-1:0];
      st_nxt     = (rt_re[W] | rt_im[W]) ? ST_OVF : ST_OK;
    end else begin
      res_re_nxt = rt_late.re;
      res_im_nxt = rt_late.im;
      alt_re_nxt = '0;
      alt_im_nxt = '0;
      st_nxt     = rt_late.st;
    end
  end

  logic            out_valid_r;
  logic [W-1:0]    out_res_re_r, out_res_im_r, out_alt_re_r, out_alt_im_r;
  logic [ST_W-1:0] out_status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= rt_vld;
    end
  end

  always_ff @(posedge clk) begin
    out_res_re_r <= res_re_nxt;
    out_res_im_r <= res_im_nxt;
    out_alt_re_r <= alt_re_nxt;
    out_alt_im_r <= alt_im_nxt;
    out_status_r <= st_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_res_re = out_res_re_r;
  assign out_res_im = out_res_im_r;
  assign out_alt_re = out_alt_re_r;
  assign out_alt_im = out_alt_im_r;
  assign out_status = out_status_r;

endmodule

`default_nettype wire

@@ tb/sv/tb_complex_arithmetic_unit.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_complex_arithmetic_unit
// Drives opcode and operand items into the complex ALU, predicts every result
// with wide integer arithmetic and compares it field by field on the strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_complex_arithmetic_unit;
  import cau_pkg::*;

  localparam int FB = FRAC_BITS_DEF;
  localparam int WB = WORD_BITS_DEF;
  localparam int LATENCY = WB + (WB + FB + 1) / 2 + 6;

  typedef logic signed [WB-1:0] word_t;
  typedef struct packed {
    word_t            res_re;
    word_t            res_im;
    word_t            alt_re;
    word_t            alt_im;
    logic [ST_W-1:0]  status;
  } cau_result_t;

  logic            clk;
  logic            rst_n;
  logic            start;
  logic            busy;
  logic [OP_W-1:0] in_opcode;
  word_t           in_a_re, in_a_im, in_b_re, in_b_im;
  logic            out_valid;
  word_t           out_res_re, out_res_im, out_alt_re, out_alt_im;
  logic [ST_W-1:0] out_status;

  cau_result_t pending_results[$];
  int          errors;
  int          results_seen;
  int          op_count[8];
  int          idle_pct;

  complex_arithmetic_unit dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_opcode(in_opcode), .in_a_re(in_a_re), .in_a_im(in_a_im),
    .in_b_re(in_b_re), .in_b_im(in_b_im),
    .out_valid(out_valid), .out_res_re(out_res_re), .out_res_im(out_res_im),
    .out_alt_re(out_alt_re), .out_alt_im(out_alt_im), .out_status(out_status)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Clamp a sign and magnitude to the word range, flagging overflow.
  function automatic word_t clamp(input bit neg, input logic [127:0] m,
                                  inout logic [ST_W-1:0] st);
    logic [127:0] lim;
    lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
    if (m > lim) begin
      st = ST_OVF;
      m = lim;
    end
    return neg ? -m[WB-1:0] : m[WB-1:0];
  endfunction

  function automatic logic [127:0] abs128(input logic signed [127:0] v);
    return v < 0 ? -v : v;
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [127:0] n);
    logic [63:0] r, t;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (n >= {64'd0, t} * {64'd0, t}) r = t;
    end
    return r;
  endfunction

  function automatic cau_result_t alu_predict(input logic [OP_W-1:0] op,
                                              input word_t ar, ai, br, bi);
    cau_result_t           r;
    logic [ST_W-1:0]       st;
    logic signed [127:0]   xr, xi, yr, yi, pr, pi, k;
    logic [127:0]          m, hr, hi;
    xr = ar; xi = ai; yr = br; yi = bi;
    st = ST_OK;
    r = '0;
    case (op)
      OP_ADD, OP_SUB: begin
        pr = (op == OP_ADD) ? xr + yr : xr - yr;
        pi = (op == OP_ADD) ? xi + yi : xi - yi;
        r.res_re = clamp(pr < 0, abs128(pr), st);
        r.res_im = clamp(pi < 0, abs128(pi), st);
      end
      OP_MUL: begin
        pr = xr * yr - xi * yi;
        pi = xr * yi + xi * yr;
        r.res_re = clamp(pr < 0, abs128(pr) >> FB, st);
        r.res_im = clamp(pi < 0, abs128(pi) >> FB, st);
      end
      OP_DIV: begin
        k = yr * yr + yi * yi;
        if (k == 0) begin
          st = ST_DIVZ;
        end else begin
          pr = xr * yr + xi * yi;
          pi = xi * yr - xr * yi;
          r.res_re = clamp(pr < 0, (abs128(pr) << FB) / k, st);
          r.res_im = clamp(pi < 0, (abs128(pi) << FB) / k, st);
        end
      end
      OP_MAG: r.res_re = clamp(1'b0, {64'd0, int_sqrt(xr * xr + xi * xi)}, st);
      OP_SQRT: begin
        m = {64'd0, int_sqrt(xr * xr + xi * xi)};
        // Half-angle roots; m >= |ar| keeps both radicands non-negative.
        hr = {64'd0, int_sqrt(((m + xr) << FB) >> 1)};
        hi = {64'd0, int_sqrt(((m - xr) << FB) >> 1)};
        r.res_re = clamp(1'b0, hr, st);
        r.res_im = clamp(ai < 0, hi, st);
        r.alt_re = -r.res_re;
        r.alt_im = -r.res_im;
      end
      OP_NEG: begin
        r.res_re = clamp(ar > 0, abs128(xr), st);
        r.res_im = clamp(ai > 0, abs128(xi), st);
      end
      default: begin
        r.res_re = ar;
        r.res_im = ai;
      end
    endcase
    r.status = st;
    return r;
  endfunction

  task automatic send_item(input logic [OP_W-1:0] op, input word_t ar, ai, br, bi);
    int gap;
    @(negedge clk);
    start = 1'b1;
    in_opcode = op;
    in_a_re = ar;
    in_a_im = ai;
    in_b_re = br;
    in_b_im = bi;
    do @(posedge clk); while (busy);
    pending_results.push_back(alu_predict(op, ar, ai, br, bi));
    op_count[op]++;
    if ($urandom_range(0, 99) < idle_pct) begin
      gap = $urandom_range(1, 4);
      @(negedge clk);
      start = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic drain_results();
    @(negedge clk);
    start = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (LATENCY + 8) @(negedge clk);
  endtask

  function automatic word_t pick_word();
    case ($urandom_range(0, 6))
      0, 1: return $urandom();
      2:    return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
      3:    return 32'sh7fff_ffff;
      4:    return 32'sh8000_0000;
      5:    return '0;
      default: return $signed($urandom_range(0, 32'h0000_0fff)) - 32'sh0000_0800;
    endcase
  endfunction

  task automatic test_directed();
    word_t mx, mn, one;
    mx = 32'sh7fff_ffff;
    mn = 32'sh8000_0000;
    one = 32'sh0001_0000;
    idle_pct = 0;
    send_item(OP_ADD, mx, mn, one, -one);
    send_item(OP_ADD, mn, mx, mn, mx);
    send_item(OP_SUB, mn, mx, one, -one);
    send_item(OP_SUB, 32'sh0003_8000, -32'sh0001_4000, one, one);
    send_item(OP_MUL, mx, mx, mx, mn);
    send_item(OP_MUL, 32'sh0002_0000, -32'sh0000_8000, -32'sh0001_8000, 32'sh0000_0003);
    send_item(OP_DIV, one, one, '0, '0);
    send_item(OP_DIV, mx, mn, 32'sh0000_0001, '0);
    send_item(OP_DIV, 32'sh0005_0000, -32'sh0003_0000, 32'sh0001_0000, 32'sh0002_0000);
    send_item(OP_MAG, mn, mn, mx, mx);
    send_item(OP_MAG, 32'sh0003_0000, -32'sh0004_0000, '0, '0);
    send_item(OP_SQRT, 32'sh0004_0000, '0, '0, '0);
    send_item(OP_SQRT, -32'sh0004_0000, '0, '0, '0);
    send_item(OP_SQRT, '0, -32'sh0002_0000, '0, '0);
    send_item(OP_SQRT, mn, mn, '0, '0);
    send_item(OP_SQRT, mx, mx, '0, '0);
    send_item(OP_SQRT, '0, '0, '0, '0);
    send_item(OP_NEG, mn, mx, one, one);
    send_item(OP_NEG, '0, -one, '0, '0);
    send_item(OP_PASS, mn, mx, mx, mn);
    send_item(OP_PASS, 32'sh1234_5678, -32'sh0765_4321, '0, '0);
    drain_results();
  endtask

  task automatic test_random(input int n, input int pct);
    logic [OP_W-1:0] op;
    word_t br, bi;
    idle_pct = pct;
    for (int i = 0; i < n; i++) begin
      op = OP_W'($urandom_range(0, 7));
      br = pick_word();
      bi = pick_word();
      if (op == OP_DIV && $urandom_range(0, 9) == 0) begin
        br = '0;
        bi = '0;
      end
      send_item(op, pick_word(), pick_word(), br, bi);
      // Let the pipeline run empty once in the middle of the phase.
      if (i == n / 2) drain_results();
    end
    drain_results();
  endtask

  always @(posedge clk) begin
    cau_result_t e;
    if (rst_n && out_valid) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t: result with no item outstanding", $time);
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (out_res_re !== e.res_re)
          $display("%0t: res_re expected %h actual %h", $time, e.res_re, out_res_re);
        if (out_res_im !== e.res_im)
          $display("%0t: res_im expected %h actual %h", $time, e.res_im, out_res_im);
        if (out_alt_re !== e.alt_re)
          $display("%0t: alt_re expected %h actual %h", $time, e.alt_re, out_alt_re);
        if (out_alt_im !== e.alt_im)
          $display("%0t: alt_im expected %h actual %h", $time, e.alt_im, out_alt_im);
        if (out_status !== e.status)
          $display("%0t: status expected %0d actual %0d", $time, e.status, out_status);
        if (out_res_re !== e.res_re || out_res_im !== e.res_im ||
            out_alt_re !== e.alt_re || out_alt_im !== e.alt_im ||
            out_status !== e.status) errors++;
      end
    end
  end

  initial begin
    #5_000_000;
    $display("complex_arithmetic_unit: mismatch");
    $finish;
  end

  initial begin
    errors = 0;
    results_seen = 0;
    idle_pct = 0;
    foreach (op_count[i]) op_count[i] = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_opcode = OP_ADD;
    in_a_re = '0;
    in_a_im = '0;
    in_b_re = '0;
    in_b_im = '0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_random(600, 27);
    test_random(500, 65);
    test_random(300, 0);
    if (pending_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, pending_results.size());
      errors++;
    end
    $display("Checked %0d results: add %0d, sub %0d, mul %0d, div %0d,", results_seen,
             op_count[OP_ADD], op_count[OP_SUB], op_count[OP_MUL], op_count[OP_DIV]);
    $display("  magnitude %0d, root %0d, negate %0d, pass %0d, under three idle mixes.",
             op_count[OP_MAG], op_count[OP_SQRT], op_count[OP_NEG], op_count[OP_PASS]);
    if (errors == 0) begin
      $display("complex_arithmetic_unit: match");
    end else begin
      $display("complex_arithmetic_unit: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ filelist.f @@
design/cau_pkg.sv
design/cau_div_pipe.sv
design/cau_isqrt_pipe.sv
design/complex_arithmetic_unit.sv
tb/sv/tb_complex_arithmetic_unit.sv
